/* rtl/hlws_pkg.sv */
// Shared types, character codes and helpers for the hex line parser.
// No dependencies; every other file imports this package.
`default_nettype none

package hlws_pkg;

  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharSemi    = 8'h3B;

  // Depth of the result queue; it must hold at least two results per item.
  localparam int unsigned ResQDepth  = 4;
  localparam int unsigned ResQPtrW   = $clog2(ResQDepth);
  localparam int unsigned ResQCntW   = $clog2(ResQDepth + 1);

  typedef enum logic [2:0] {
    PH_LINE,
    PH_LINE_COMMENT,
    PH_ADDR,
    PH_SPACE,
    PH_DATA,
    PH_AFTER_DATA,
    PH_WHITE,
    PH_TAIL_COMMENT
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_CR_NO_LF     = 4'd0,
    ERR_EMPTY_LINE   = 4'd1,
    ERR_EOF_COMMENT  = 4'd2,
    ERR_BAD_ADDRESS  = 4'd3,
    ERR_NO_SPACE     = 4'd4,
    ERR_ADDR_BELOW   = 4'd5,
    ERR_BAD_DATA     = 4'd6,
    ERR_NO_WHITE     = 4'd7,
    ERR_NO_NEWLINE   = 4'd8
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] word;
    logic [31:0] fill;
    err_e        err;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Letters a..f and A..F share the low nibble 1..6.
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/hlws_parser.sv */
// Line parser state and per-character decode; yields up to two results.
// Depends on hlws_pkg.
`default_nettype none

module hlws_parser
  import hlws_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  wire logic [7:0] item_char_i,
  input  wire logic       item_eof_i,
  output logic [1:0]      res_cnt_o,
  output result_t         res0_o,
  output result_t         res1_o
);

  phase_e       phase_q, phase_d;
  logic [2:0]   nib_q, nib_d;
  logic [31:0]  addr_q, addr_d;
  logic [31:0]  data_q, data_d;
  logic [32:0]  wcount_q, wcount_d;
  logic         pend_cr_q, pend_cr_d;
  logic         halted_q, halted_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LINE;
      nib_q     <= '0;
      addr_q    <= '0;
      data_q    <= '0;
      wcount_q  <= '0;
      pend_cr_q <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      nib_q     <= nib_d;
      addr_q    <= addr_d;
      data_q    <= data_d;
      wcount_q  <= wcount_d;
      pend_cr_q <= pend_cr_d;
      halted_q  <= halted_d;
    end
  end

  logic [32:0] addr_ext;
  assign addr_ext = {1'b0, addr_q};

  always_comb begin
    logic       do_proc;
    logic [7:0] c;
    logic       e;
    logic       err_hit;
    err_e       err_code;
    logic       fin;
    logic       end_hit;
    hex_t       hv;

    phase_d   = phase_q;
    nib_d     = nib_q;
    addr_d    = addr_q;
    data_d    = data_q;
    wcount_d  = wcount_q;
    pend_cr_d = pend_cr_q;
    halted_d  = halted_q;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    do_proc   = 1'b0;
    c         = item_char_i;
    e         = item_eof_i;
    err_hit   = 1'b0;
    err_code  = ERR_CR_NO_LF;
    fin       = 1'b0;
    end_hit   = 1'b0;
    hv        = hex_digit(item_char_i);

    if (item_valid_i && !halted_q) begin
      // A CR is only legal as the first half of a CR LF pair.
      if (pend_cr_q) begin
        pend_cr_d = 1'b0;
        if (item_eof_i || item_char_i != CharLf) begin
          err_hit  = 1'b1;
          err_code = ERR_CR_NO_LF;
        end else begin
          do_proc = 1'b1;
          c       = CharLf;
          e       = 1'b0;
        end
      end else if (!item_eof_i && item_char_i == CharCr) begin
        pend_cr_d = 1'b1;
      end else begin
        do_proc = 1'b1;
      end

      if (do_proc) begin
        unique case (phase_q)
          PH_LINE: begin
            if (e) begin
              end_hit = 1'b1;
            end else if (c == CharLf) begin
              err_hit  = 1'b1;
              err_code = ERR_EMPTY_LINE;
            end else if (c == CharSemi) begin
              phase_d = PH_LINE_COMMENT;
            end else if (!hv.ok) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_ADDRESS;
            end else begin
              addr_d  = {28'd0, hv.val};
              nib_d   = 3'd1;
              phase_d = PH_ADDR;
            end
          end
          PH_LINE_COMMENT: begin
            if (e) begin
              err_hit  = 1'b1;
              err_code = ERR_EOF_COMMENT;
            end else if (c == CharLf) begin
              phase_d = PH_LINE;
            end
          end
          PH_ADDR: begin
            if (e || !hv.ok) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_ADDRESS;
            end else begin
              addr_d = {addr_q[27:0], hv.val};
              nib_d  = nib_q + 3'd1;
              if (nib_q == 3'd7) phase_d = PH_SPACE;
            end
          end
          PH_SPACE: begin
            if (e || c != CharSpace) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_SPACE;
            end else begin
              data_d  = '0;
              nib_d   = 3'd0;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            // The address order check comes before the digit check.
            if (nib_q == 3'd0 && wcount_q > addr_ext) begin
              err_hit  = 1'b1;
              err_code = ERR_ADDR_BELOW;
            end else if (e || !hv.ok) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_DATA;
            end else begin
              data_d = {data_q[27:0], hv.val};
              nib_d  = nib_q + 3'd1;
              if (nib_q == 3'd7) phase_d = PH_AFTER_DATA;
            end
          end
          PH_AFTER_DATA: begin
            if (e) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_WHITE;
            end else if (c == CharSpace || c == CharTab) begin
              phase_d = PH_WHITE;
            end else if (c == CharSemi) begin
              phase_d = PH_TAIL_COMMENT;
            end else if (c == CharLf) begin
              fin = 1'b1;
            end else begin
              err_hit  = 1'b1;
              err_code = ERR_NO_WHITE;
            end
          end
          PH_WHITE: begin
            if (e) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_NEWLINE;
            end else if (c == CharSpace || c == CharTab) begin
              phase_d = PH_WHITE;
            end else if (c == CharSemi) begin
              phase_d = PH_TAIL_COMMENT;
            end else if (c == CharLf) begin
              fin = 1'b1;
            end else begin
              err_hit  = 1'b1;
              err_code = ERR_NO_NEWLINE;
            end
          end
          PH_TAIL_COMMENT: begin
            if (e) begin
              err_hit  = 1'b1;
              err_code = ERR_EOF_COMMENT;
            end else if (c == CharLf) begin
              fin = 1'b1;
            end
          end
        endcase
      end

      if (err_hit) begin
        res_cnt_o   = 2'd1;
        res0_o.kind = KIND_ERROR;
        res0_o.err  = err_code;
        res0_o.last = 1'b1;
        halted_d    = 1'b1;
      end else if (end_hit) begin
        res_cnt_o   = 2'd1;
        res0_o.kind = KIND_END;
        res0_o.last = 1'b1;
        halted_d    = 1'b1;
      end else if (fin) begin
        // A gap between the running count and the address becomes a zero run.
        if (wcount_q < addr_ext) begin
          res_cnt_o   = 2'd2;
          res0_o.kind = KIND_FILL;
          res0_o.fill = addr_q - wcount_q[31:0];
          res1_o.kind = KIND_WORD;
          res1_o.word = data_q;
          res1_o.last = 1'b1;
        end else begin
          res_cnt_o   = 2'd1;
          res0_o.kind = KIND_WORD;
          res0_o.word = data_q;
          res0_o.last = 1'b1;
        end
        wcount_d = addr_ext + 33'd1;
        phase_d  = PH_LINE;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/hlws_res_queue.sv */
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on hlws_pkg.
`default_nettype none

module hlws_res_queue
  import hlws_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           push_cnt_i,
  input  wire result_t              wdata0_i,
  input  wire result_t              wdata1_i,
  input  wire logic                 pop_i,
  output logic [ResQCntW-1:0]       count_o,
  output result_t                   head_o
);

  result_t               entries_q [ResQDepth];
  logic [ResQPtrW-1:0]   wptr_q, rptr_q;
  logic [ResQCntW-1:0]   count_q;
  logic [ResQPtrW-1:0]   wptr_nx;

  assign wptr_nx = wptr_q + ResQPtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + ResQPtrW'(push_cnt_i);
      if (pop_i) rptr_q <= rptr_q + ResQPtrW'(1);
      count_q <= count_q + ResQCntW'(push_cnt_i) - ResQCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) entries_q[wptr_q] <= wdata0_i;
    if (push_cnt_i == 2'd2) entries_q[wptr_nx] <= wdata1_i;
  end

  assign count_o = count_q;
  assign head_o  = entries_q[rptr_q];

endmodule

`default_nettype wire

/* rtl/hex_line_to_word_stream.sv */
// Flow: an accepted character is held in the input register, parsed once the queue
// has room for two results, and its results are written to the queue and offered.
// Throughput: one character per cycle while the queue has room for two results; a completed line
// queues at most two results, which leave at one per cycle when out_stall_i is low, through a four-entry result queue.
// Reset (rst_ni, asynchronous, active low) returns the parser to line start with a
// zero word count, empties the queue and clears the halt after an error or end.
`default_nettype none

module hex_line_to_word_stream
  import hlws_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        end_of_input_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      word_value_o,
  output logic [31:0]      fill_count_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);

  logic                item_valid_q;
  logic [7:0]          item_char_q;
  logic                item_eof_q;
  logic                consume;
  logic                accept;
  logic [1:0]          res_cnt;
  result_t             res0, res1, head;
  logic [ResQCntW-1:0] q_count;
  logic                pop;

  // The held request moves on only when the queue has room for two results.
  assign consume    = item_valid_q && (q_count <= ResQCntW'(ResQDepth - 2));
  assign in_stall_o = item_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (consume) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_char_q <= in_char_i;
      item_eof_q  <= end_of_input_i;
    end
  end

  hlws_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (consume),
    .item_char_i  (item_char_q),
    .item_eof_i   (item_eof_q),
    .res_cnt_o    (res_cnt),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  hlws_res_queue u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .wdata0_i   (res0),
    .wdata1_i   (res1),
    .pop_i      (pop),
    .count_o    (q_count),
    .head_o     (head)
  );

  assign out_valid_o  = (q_count != '0);
  assign pop          = out_valid_o && !out_stall_i;
  assign kind_o       = head.kind;
  assign word_value_o = head.word;
  assign fill_count_o = head.fill;
  assign error_code_o = head.err;
  assign last_o       = head.last;

endmodule

`default_nettype wire

/* rtl/hlws_checker.sv */
// Port-level checks for the hex line parser, bound to the top level.
// Depends on hlws_pkg for the result kind and error codes.
`default_nettype none

module hlws_checker
  import hlws_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [31:0] word_value_o,
  input wire logic [31:0] fill_count_o,
  input wire logic [3:0]  error_code_o,
  input wire logic        last_o
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(word_value_o) && $stable(fill_count_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // A zero run is never empty and is always followed by its data word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FILL |-> fill_count_o != 32'd0 && !last_o)
    else $error("bad zero-fill result");

  // Data words, errors and the end mark close the request's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_FILL |-> last_o)
    else $error("final result without last");

  // Error codes are in range on error results; other results carry a zero code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_ERROR) ? (error_code_o <= ERR_NO_NEWLINE)
                                           : (error_code_o == 4'd0))
    else $error("bad error code");

  // Nothing follows an error or the end mark until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == KIND_ERROR || kind_o == KIND_END)
      |=> !out_valid_o)
    else $error("result after halt");

endmodule

bind hex_line_to_word_stream hlws_checker u_hlws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .word_value_o (word_value_o),
  .fill_count_o (fill_count_o),
  .error_code_o (error_code_o),
  .last_o       (last_o)
);

`default_nettype wire
